FILE: sv/supply_sensor_monitor_unit_defines.svh
`ifndef SUPPLY_SENSOR_MONITOR_UNIT_DEFINES_SVH
`define SUPPLY_SENSOR_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SSM_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SSM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

   localparam int unsigned SAMPLE_W    = 8;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned ACC_W       = 15;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REG_IDX_W   = 3;
   localparam int unsigned RSP_DATA_W  = 64;

   localparam logic [ACC_W-1:0] ACC_MAX = 15'd25500;

   localparam logic [KIND_W-1:0] KIND_CURRENT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_VOLT_ONE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VOLT_TWO  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MOTOR     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BOARD     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READOUT   = 3'd5;

   localparam logic [REG_IDX_W-1:0] REG_VOLT_GOOD      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SUPPLY_PRESENT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_MIN       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_MAX       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW_CODE  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH_CODE = 3'd5;

   typedef enum logic [2:0] {
      OP_CURRENT,
      OP_VOLT_ONE,
      OP_VOLT_TWO,
      OP_MOTOR,
      OP_BOARD,
      OP_READOUT,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
      logic [ACC_W-1:0]    acc;
   } stage_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] volt_good_level;
      logic [SAMPLE_W-1:0] supply_present_level;
      logic [SAMPLE_W-1:0] temp_valid_min;
      logic [SAMPLE_W-1:0] temp_valid_max;
      logic [SAMPLE_W-1:0] temp_low_code;
      logic [SAMPLE_W-1:0] temp_high_code;
   } cfg_type;

   // first field in the highest bits
   typedef struct packed {
      logic                board_temp_ok;
      logic [SAMPLE_W-1:0] board_temp;
      logic                motor_temp_ok;
      logic [SAMPLE_W-1:0] motor_temp;
      logic                supply_present;
      logic                volts_good;
      logic [SAMPLE_W-1:0] voltage_two;
      logic [SAMPLE_W-1:0] voltage_one;
      logic [SAMPLE_W-1:0] lowest_voltage;
      logic [SAMPLE_W-1:0] peak_current;
      logic [SAMPLE_W-1:0] filtered_current;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

`default_nettype wire

FILE: sv/ssm_front.sv
`default_nettype none

module ssm_front
   import ssm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]   req_tuser,
   output logic                item_valid,
   input  logic                item_ready,
   output item_type            item
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   item_type         entry_ff [QUEUE_DEPTH];
   item_type         entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   always_comb begin
      entry_in.sample = req_tdata;
      case (req_tuser)
         KIND_CURRENT:  entry_in.op = OP_CURRENT;
         KIND_VOLT_ONE: entry_in.op = OP_VOLT_ONE;
         KIND_VOLT_TWO: entry_in.op = OP_VOLT_TWO;
         KIND_MOTOR:    entry_in.op = OP_MOTOR;
         KIND_BOARD:    entry_in.op = OP_BOARD;
         KIND_READOUT:  entry_in.op = OP_READOUT;
         default:       entry_in.op = OP_QUERY;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ssm_filter.sv
`default_nettype none

module ssm_filter
   import ssm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   output logic      item_ready,
   input  item_type  item,
   output logic      stage_valid,
   input  logic      stage_ready,
   output stage_type stage
);

   localparam int unsigned SUM_W      = 23;
   localparam int unsigned PROD_W     = 39;
   localparam int unsigned RECIP_SH   = 23;
   localparam int unsigned Q_W        = PROD_W - RECIP_SH;
   localparam int unsigned FILT_COEFF = 200;
   localparam int unsigned FILT_GAIN  = 5500;

   // acc' = (acc*200 + s*5500) / 255, reciprocal 32897 / 2^23 with one correction
   function automatic logic [ACC_W-1:0] filter_update(input logic [ACC_W-1:0] acc,
                                                      input logic [SAMPLE_W-1:0] s);
      logic [SUM_W-1:0]  x;
      logic [PROD_W-1:0] prod;
      logic [Q_W-1:0]    q;
      logic [Q_W+7:0]    back;
      x    = SUM_W'(acc) * SUM_W'(FILT_COEFF) + SUM_W'(s) * SUM_W'(FILT_GAIN);
      prod = PROD_W'(x) + (PROD_W'(x) << 7) + (PROD_W'(x) << 15);
      q    = prod[PROD_W-1:RECIP_SH];
      back = {q, 8'd0} - (Q_W+8)'(q);
      if (back > (Q_W+8)'(x)) begin
         q = q - Q_W'(1);
      end
      return q[ACC_W-1:0];
   endfunction

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             valid_ff;
   stage_type        stage_ff;
   logic             take;

   assign item_ready  = !valid_ff || stage_ready;
   assign take        = item_valid && item_ready;
   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

   always_comb begin
      acc_in = acc_ff;
      if (take && item.op == OP_CURRENT) begin
         acc_in = filter_update(acc_ff, item.sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (item_ready) begin
            valid_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff.op     <= item.op;
         stage_ff.sample <= item.sample;
         stage_ff.acc    <= acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ssm_status.sv
`default_nettype none

module ssm_status
   import ssm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       stage_valid,
   output logic       stage_ready,
   input  stage_type  stage,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type result
);

   localparam int unsigned LVL_W     = ACC_W + 13;
   localparam int unsigned LVL_SHIFT = 19;
   localparam int unsigned LVL_RECIP = 5243;
   localparam int unsigned LVL_ROUND = 50;

   // (acc + 50) / 100, exact while acc + 50 stays below 2^15
   function automatic logic [SAMPLE_W-1:0] level_of(input logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0] y;
      logic [LVL_W-1:0] prod;
      y    = acc + ACC_W'(LVL_ROUND);
      prod = LVL_W'(y) * LVL_W'(LVL_RECIP);
      return prod[LVL_SHIFT +: SAMPLE_W];
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_temp(input logic [SAMPLE_W-1:0] raw,
                                                      input cfg_type c);
      logic [SAMPLE_W-1:0] r;
      r = raw;
      if (raw < c.temp_valid_min) begin
         r = c.temp_low_code;
      end else if (raw > c.temp_valid_max) begin
         r = c.temp_high_code;
      end
      return r;
   endfunction

   logic [SAMPLE_W-1:0] level_ff, level_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] low_mark_ff, low_mark_in;
   logic [SAMPLE_W-1:0] supply_one_ff, supply_one_in;
   logic [SAMPLE_W-1:0] supply_two_ff, supply_two_in;
   logic [SAMPLE_W-1:0] motor_ff, motor_in;
   logic [SAMPLE_W-1:0] board_ff, board_in;
   logic [SAMPLE_W-1:0] peak_out;
   logic                out_valid_ff;
   result_type          result_ff, result_in;
   logic                take;

   assign stage_ready = !out_valid_ff || rsp_ready;
   assign take        = stage_valid && stage_ready;
   assign rsp_valid   = out_valid_ff;
   assign result      = result_ff;

   always_comb begin
      level_in      = level_ff;
      peak_in       = peak_ff;
      low_mark_in   = low_mark_ff;
      supply_one_in = supply_one_ff;
      supply_two_in = supply_two_ff;
      motor_in      = motor_ff;
      board_in      = board_ff;
      peak_out      = peak_ff;
      case (stage.op)
         OP_CURRENT: begin
            level_in = level_of(stage.acc);
            if (stage.sample > peak_ff) begin
               peak_in = stage.sample;
            end
            peak_out = peak_in;
         end
         OP_VOLT_ONE: begin
            supply_one_in = stage.sample;
            if (low_mark_ff == '0 || stage.sample < low_mark_ff) begin
               low_mark_in = stage.sample;
            end
         end
         OP_VOLT_TWO: supply_two_in = stage.sample;
         OP_MOTOR:    motor_in = stage.sample;
         OP_BOARD:    board_in = stage.sample;
         OP_READOUT:  peak_in = level_ff;
         default: ;
      endcase

      result_in.filtered_current = level_in;
      result_in.peak_current     = peak_out;
      result_in.lowest_voltage   = low_mark_in;
      result_in.voltage_one      = supply_one_in;
      result_in.voltage_two      = supply_two_in;
      result_in.volts_good       = (supply_one_in >= cfg.volt_good_level) &&
                                   (supply_two_in >= cfg.volt_good_level);
      result_in.supply_present   = (supply_one_in >= cfg.supply_present_level) ||
                                   (supply_two_in >= cfg.supply_present_level);
      result_in.motor_temp       = clamp_temp(motor_in, cfg);
      result_in.motor_temp_ok    = !(motor_in == cfg.temp_low_code ||
                                     motor_in == cfg.temp_high_code);
      result_in.board_temp       = clamp_temp(board_in, cfg);
      result_in.board_temp_ok    = !(board_in == cfg.temp_low_code ||
                                     board_in == cfg.temp_high_code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         peak_ff       <= '0;
         low_mark_ff   <= '0;
         supply_one_ff <= '0;
         supply_two_ff <= '0;
         motor_ff      <= '0;
         board_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            level_ff      <= level_in;
            peak_ff       <= peak_in;
            low_mark_ff   <= low_mark_in;
            supply_one_ff <= supply_one_in;
            supply_two_ff <= supply_two_in;
            motor_ff      <= motor_in;
            board_ff      <= board_in;
         end
         if (stage_ready) begin
            out_valid_ff <= stage_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/supply_sensor_monitor_unit.sv
// channel  | dir | handshake          | payload
// req      | in  | tvalid/tready      | tdata sample, tuser kind
// rsp      | out | tvalid/tready      | tdata status snapshot, one per request
// csr      | in  | psel/penable/pwrite| six 8-bit registers at 4*index
//
// one transaction per cycle sustained while rsp_tready stays high; rsp_tvalid rises once
// the request has passed the queue, the filter stage and the status/output register
// the filter accumulator update is combinational and sets the rate
// a stalled rsp holds its data; the two-entry queue fills and then req_tready drops
// reset is synchronous: clears the pipeline and state, registers take their defaults
`default_nettype none

`include "supply_sensor_monitor_unit_defines.svh"

module supply_sensor_monitor_unit
   import ssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [7:0] sample
   input  logic [KIND_W-1:0]     req_tuser,   // [2:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] filtered_current, [15:8] peak_current, [23:16] lowest_voltage,
   // [31:24] voltage_one, [39:32] voltage_two, [40] volts_good,
   // [41] supply_present, [49:42] motor_temp, [50] motor_temp_ok,
   // [58:51] board_temp, [59] board_temp_ok, [63:60] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                 cfg_ff;
   logic [REG_IDX_W-1:0]    reg_idx;
   logic [SAMPLE_W-1:0]     rd_value;
   logic                    item_valid;
   logic                    item_ready;
   item_type                item;
   logic                    stage_valid;
   logic                    stage_ready;
   stage_type               stage;
   result_type              result;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_good_level      <= 8'd100;
         cfg_ff.supply_present_level <= 8'd20;
         cfg_ff.temp_valid_min       <= 8'd10;
         cfg_ff.temp_valid_max       <= 8'd200;
         cfg_ff.temp_low_code        <= 8'd0;
         cfg_ff.temp_high_code       <= 8'd255;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (reg_idx)
            REG_VOLT_GOOD:      cfg_ff.volt_good_level      <= csr_pwdata[SAMPLE_W-1:0];
            REG_SUPPLY_PRESENT: cfg_ff.supply_present_level <= csr_pwdata[SAMPLE_W-1:0];
            REG_TEMP_MIN:       cfg_ff.temp_valid_min       <= csr_pwdata[SAMPLE_W-1:0];
            REG_TEMP_MAX:       cfg_ff.temp_valid_max       <= csr_pwdata[SAMPLE_W-1:0];
            REG_TEMP_LOW_CODE:  cfg_ff.temp_low_code        <= csr_pwdata[SAMPLE_W-1:0];
            REG_TEMP_HIGH_CODE: cfg_ff.temp_high_code       <= csr_pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_VOLT_GOOD:      rd_value = cfg_ff.volt_good_level;
         REG_SUPPLY_PRESENT: rd_value = cfg_ff.supply_present_level;
         REG_TEMP_MIN:       rd_value = cfg_ff.temp_valid_min;
         REG_TEMP_MAX:       rd_value = cfg_ff.temp_valid_max;
         REG_TEMP_LOW_CODE:  rd_value = cfg_ff.temp_low_code;
         REG_TEMP_HIGH_CODE: rd_value = cfg_ff.temp_high_code;
         default:            rd_value = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_value);

   ssm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   ssm_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   ssm_status u_status (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .result      (result)
   );

   assign rsp_tdata = {(RSP_DATA_W - RESULT_W)'(0), result};

   `SSM_ASSERT_NEXT(a_accept_queued, clock, reset, req_tvalid && req_tready, item_valid, "accepted request missing from queue")
   `SSM_ASSERT_IMPLY(a_acc_range, clock, reset, stage_valid, stage.acc <= ACC_MAX, "filter accumulator out of range")
   `SSM_ASSERT_IMPLY(a_low_mark, clock, reset, rsp_tvalid && result.voltage_one != 8'd0, result.lowest_voltage != 8'd0 && result.lowest_voltage <= result.voltage_one, "low-water mark above voltage one")

endmodule

`default_nettype wire
